### rtl/core/energy_vad_turn_endpointer_macros.svh
// Assertion macros shared by the endpointer RTL.
`ifndef ENERGY_VAD_TURN_ENDPOINTER_MACROS_SVH
`define ENERGY_VAD_TURN_ENDPOINTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EVTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EVTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/evte_pkg.sv
// Package: types, constants and codes of the energy VAD turn endpointer.
`default_nettype none

package evte_pkg;

  localparam int FRAME_SAMPLES = 320;
  localparam int FRAME_BITS    = $clog2(FRAME_SAMPLES);
  localparam int FILL_W        = FRAME_BITS;
  localparam int ACC_W         = 30 + $clog2(FRAME_SAMPLES + 1);
  localparam int ENERGY_SHIFT  = 12;
  localparam int ENERGY_W      = 15;
  localparam int SPEECH_W      = 8;
  localparam int COUNT_W       = 16;
  localparam int SEQ_W         = 32;
  localparam int REQ_W         = 3;
  localparam int SAMPLE_W      = 16;
  localparam int SQ_W          = 2 * SAMPLE_W;

  // Divide by FRAME_SAMPLES through a reciprocal multiply on the pre-shifted sum.
  localparam int QX_W        = ENERGY_W + FRAME_BITS;
  localparam int RECIP_SHIFT = ENERGY_W + 2 * FRAME_BITS;
  localparam int RECIP_W     = RECIP_SHIFT - FRAME_BITS + 2;
  localparam int PROD_W      = QX_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + 64'(FRAME_SAMPLES) - 64'd1) / 64'(FRAME_SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam logic [ACC_W-1:0] ENERGY_SAT_LIM =
    ACC_W'(64'(FRAME_SAMPLES) << (ENERGY_W + ENERGY_SHIFT));
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(FRAME_SAMPLES - 1);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_SAMPLE     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_TURN_DONE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CALL_START = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RESTART    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SEQ_RESET  = 3'd4;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENERGY_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_AGENT_MODE       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SPEECH       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_COLLECTED    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SILENCE_LIMIT    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_COLLECTED    = 3'd5;

  localparam logic [ENERGY_W-1:0] RST_ENERGY_THRESHOLD = 15'd0;
  localparam logic                RST_AGENT_MODE       = 1'b1;
  localparam logic [SPEECH_W-1:0] RST_MIN_SPEECH       = 8'd2;
  localparam logic [COUNT_W-1:0]  RST_MIN_COLLECTED    = 16'd5;
  localparam logic [COUNT_W-1:0]  RST_SILENCE_LIMIT    = 16'd40;
  localparam logic [COUNT_W-1:0]  RST_MAX_COLLECTED    = 16'd750;

  typedef struct packed {
    logic [REQ_W-1:0]           req_type;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       call_active;
  } in_item_t;

  typedef struct packed {
    logic                frame_done;
    logic [ENERGY_W-1:0] frame_energy;
    logic [SEQ_W-1:0]    frame_seq;
    logic                commit;
    logic [SEQ_W-1:0]    turn_id;
    logic                pending;
  } out_item_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy_threshold;
    logic                agent_mode;
    logic [SPEECH_W-1:0] min_speech_frames;
    logic [COUNT_W-1:0]  min_collected_frames;
    logic [COUNT_W-1:0]  silence_limit;
    logic [COUNT_W-1:0]  max_collected_frames;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic                call_active;
    logic                frame_done;
    logic [ENERGY_W-1:0] energy;
  } frame_t;

endpackage

`default_nettype wire

### rtl/core/evte_cfg_regs.sv
// Configuration register file of the endpointer.
`default_nettype none

module evte_cfg_regs import evte_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.energy_threshold     <= RST_ENERGY_THRESHOLD;
      cfg_r.agent_mode           <= RST_AGENT_MODE;
      cfg_r.min_speech_frames    <= RST_MIN_SPEECH;
      cfg_r.min_collected_frames <= RST_MIN_COLLECTED;
      cfg_r.silence_limit        <= RST_SILENCE_LIMIT;
      cfg_r.max_collected_frames <= RST_MAX_COLLECTED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENERGY_THRESHOLD: cfg_r.energy_threshold     <= cfg_data[ENERGY_W-1:0];
        CFG_AGENT_MODE:       cfg_r.agent_mode           <= cfg_data[0];
        CFG_MIN_SPEECH:       cfg_r.min_speech_frames    <= cfg_data[SPEECH_W-1:0];
        CFG_MIN_COLLECTED:    cfg_r.min_collected_frames <= cfg_data[COUNT_W-1:0];
        CFG_SILENCE_LIMIT:    cfg_r.silence_limit        <= cfg_data[COUNT_W-1:0];
        CFG_MAX_COLLECTED:    cfg_r.max_collected_frames <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/evte_frame_energy.sv
// Frame energy pipeline: input register, square, accumulate, scale and saturate.
`default_nettype none

`include "energy_vad_turn_endpointer_macros.svh"

module evte_frame_energy import evte_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          fe_valid,
  input  wire logic     fe_stall,
  output frame_t        fe_item
);

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             call_active;
    logic [SQ_W-1:0]  sq;
  } sq_item_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             call_active;
    logic             frame_done;
    logic [ACC_W-1:0] total;
  } sum_item_t;

  logic      s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  in_item_t  s1_r;
  sq_item_t  s2_r;
  sum_item_t s3_r;
  frame_t    s4_r;
  logic      s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  sum_item_t         s3_nxt;
  logic [ACC_W-1:0]  acc_sum;

  logic [SAMPLE_W-1:0] mag;
  logic [SQ_W-1:0]     sq;
  logic                sat;
  logic [QX_W-1:0]     qx;
  logic [PROD_W-1:0]   prod;
  frame_t              s4_nxt;

  assign s4_rdy   = !s4_v_r || !fe_stall;
  assign s3_rdy   = !s3_v_r || s4_rdy;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_stall = !s1_rdy;
  assign fe_valid = s4_v_r;
  assign fe_item  = s4_r;

  // |sample|, then its square
  assign mag = s1_r.sample[SAMPLE_W-1] ? SAMPLE_W'(-s1_r.sample) : SAMPLE_W'(s1_r.sample);
  assign sq  = SQ_W'(mag) * SQ_W'(mag);

  always_comb begin
    acc_sum            = acc_r + ACC_W'(s2_r.sq);
    fill_nxt           = fill_r;
    acc_nxt            = acc_r;
    s3_nxt.req_type    = s2_r.req_type;
    s3_nxt.call_active = s2_r.call_active;
    s3_nxt.frame_done  = 1'b0;
    s3_nxt.total       = acc_sum;
    if (s2_r.req_type == REQ_SAMPLE) begin
      if (fill_r == FILL_LAST) begin
        s3_nxt.frame_done = 1'b1;
        fill_nxt          = '0;
        acc_nxt           = '0;
      end else begin
        fill_nxt = fill_r + FILL_W'(1);
        acc_nxt  = acc_sum;
      end
    end else if (s2_r.req_type == REQ_RESTART) begin
      fill_nxt = '0;
      acc_nxt  = '0;
    end
  end

  // (sum >> 12) / FRAME_SAMPLES, saturated
  assign sat  = s3_r.total >= ENERGY_SAT_LIM;
  assign qx   = s3_r.total[ENERGY_SHIFT +: QX_W];
  assign prod = PROD_W'(qx) * PROD_W'(RECIP);

  always_comb begin
    s4_nxt.req_type    = s3_r.req_type;
    s4_nxt.call_active = s3_r.call_active;
    s4_nxt.frame_done  = s3_r.frame_done;
    s4_nxt.energy      = sat ? ENERGY_MAX : prod[RECIP_SHIFT +: ENERGY_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      fill_r <= '0;
      acc_r  <= '0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (s4_rdy) s4_v_r <= s3_v_r;
      if (s2_v_r && s3_rdy) begin
        fill_r <= fill_nxt;
        acc_r  <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_rdy) s1_r <= in_data;
    if (s1_v_r && s2_rdy) begin
      s2_r.req_type    <= s1_r.req_type;
      s2_r.call_active <= s1_r.call_active;
      s2_r.sq          <= sq;
    end
    if (s2_v_r && s3_rdy) s3_r <= s3_nxt;
    if (s3_v_r && s4_rdy) s4_r <= s4_nxt;
  end

  `EVTE_ASSERT_NOW(a_fill_range, clk, rst_n, 1'b1, fill_r <= FILL_LAST,
                   "fill count past frame end")
  `EVTE_ASSERT_NOW(a_done_on_sample, clk, rst_n, s3_v_r && s3_r.frame_done,
                   s3_r.req_type == REQ_SAMPLE, "frame end on a non-sample item")
  `EVTE_ASSERT_NOW(a_quot_fits, clk, rst_n, s3_v_r && !sat,
                   (prod >> RECIP_SHIFT) <= PROD_W'(ENERGY_MAX), "unsaturated energy overflows")

endmodule

`default_nettype wire

### rtl/core/evte_turn_ctrl.sv
// Turn detection counters, sequence numbering and the result register.
`default_nettype none

`include "energy_vad_turn_endpointer_macros.svh"

module evte_turn_ctrl import evte_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire logic   fe_valid,
  output logic        fe_stall,
  input  wire frame_t fe_item,
  output logic        out_valid,
  input  wire logic   out_stall,
  output out_item_t   out_data
);

  logic      out_v_r;
  out_item_t out_r, out_nxt;
  logic      rdy, load;

  logic [SPEECH_W-1:0] speech_r, speech_nxt;
  logic [COUNT_W-1:0]  silence_r, silence_nxt;
  logic [COUNT_W-1:0]  coll_r, coll_nxt;
  logic                wait_r, wait_nxt;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic [SEQ_W-1:0]    turn_r, turn_nxt;

  assign rdy       = !out_v_r || !out_stall;
  assign load      = fe_valid && rdy;
  assign fe_stall  = !rdy;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    logic [SPEECH_W-1:0] sp_a;
    logic [COUNT_W-1:0]  si_a;
    logic [COUNT_W-1:0]  co_a;
    speech_nxt  = speech_r;
    silence_nxt = silence_r;
    coll_nxt    = coll_r;
    wait_nxt    = wait_r;
    seq_nxt     = seq_r;
    turn_nxt    = turn_r;
    out_nxt     = '0;
    sp_a        = speech_r;
    si_a        = silence_r;
    co_a        = coll_r;
    unique case (fe_item.req_type)
      REQ_SAMPLE: begin
        if (fe_item.frame_done) begin
          out_nxt.frame_done   = 1'b1;
          out_nxt.frame_energy = fe_item.energy;
          out_nxt.frame_seq    = seq_r;
          seq_nxt              = seq_r + SEQ_W'(1);
          if (fe_item.call_active && !wait_r && cfg.agent_mode) begin
            if (fe_item.energy > cfg.energy_threshold) begin
              if (speech_r != '1) sp_a = speech_r + SPEECH_W'(1);
              si_a = '0;
            end else if (speech_r != '0) begin
              if (silence_r != '1) si_a = silence_r + COUNT_W'(1);
            end
            if (sp_a >= cfg.min_speech_frames && coll_r != '1) co_a = coll_r + COUNT_W'(1);
            if (co_a >= cfg.min_collected_frames &&
                (si_a >= cfg.silence_limit || co_a >= cfg.max_collected_frames)) begin
              wait_nxt        = 1'b1;
              turn_nxt        = turn_r + SEQ_W'(1);
              out_nxt.commit  = 1'b1;
              out_nxt.turn_id = turn_r + SEQ_W'(1);
              speech_nxt      = '0;
              silence_nxt     = '0;
              coll_nxt        = '0;
            end else begin
              speech_nxt  = sp_a;
              silence_nxt = si_a;
              coll_nxt    = co_a;
            end
          end
        end
      end
      REQ_TURN_DONE: begin
        wait_nxt    = 1'b0;
        speech_nxt  = '0;
        silence_nxt = '0;
        coll_nxt    = '0;
      end
      REQ_CALL_START: begin
        seq_nxt  = '0;
        wait_nxt = 1'b0;
      end
      REQ_RESTART: begin
        seq_nxt     = '0;
        wait_nxt    = 1'b0;
        speech_nxt  = '0;
        silence_nxt = '0;
        coll_nxt    = '0;
      end
      REQ_SEQ_RESET: seq_nxt = '0;
      default: ;
    endcase
    out_nxt.pending = wait_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      speech_r  <= '0;
      silence_r <= '0;
      coll_r    <= '0;
      wait_r    <= 1'b0;
      seq_r     <= '0;
      turn_r    <= '0;
    end else begin
      if (rdy) out_v_r <= fe_valid;
      if (load) begin
        speech_r  <= speech_nxt;
        silence_r <= silence_nxt;
        coll_r    <= coll_nxt;
        wait_r    <= wait_nxt;
        seq_r     <= seq_nxt;
        turn_r    <= turn_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= out_nxt;
  end

  `EVTE_ASSERT_NOW(a_commit_pending, clk, rst_n, out_v_r && out_r.commit,
                   out_r.pending && out_r.frame_done, "commit without pending or frame")
  `EVTE_ASSERT_NEXT(a_turn_only_commit, clk, rst_n, !(load && out_nxt.commit),
                    $stable(turn_r), "turn counter moved without commit")
  `EVTE_ASSERT_NEXT(a_pending_tracks, clk, rst_n, load, out_r.pending == wait_r,
                    "pending differs from turn wait")

endmodule

`default_nettype wire

### rtl/core/energy_vad_turn_endpointer.sv
// Energy VAD turn endpointer: top level.
//
// Input channel (in_valid / in_stall / in_data): one request per item. A sample
// request adds one PCM sample to the current frame; turn done, call started,
// audio restart and sequence reset requests act on the turn state.
// Output channel (out_valid / out_stall / out_data): exactly one result per
// input item, in order. frame_done marks the sample that closed a frame and
// carries its energy and sequence number; commit marks a turn end.
// Config port (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready,
// write only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled; five register stages
// (input, square, accumulate, reciprocal scale, result) each take one item per cycle.
// Reset (rst_n low, synchronous): pipeline empties, counters and the turn
// state clear, registers take their default values.
// A stalled result holds; items keep entering until every stage is full,
// then in_stall rises.
`default_nettype none

module energy_vad_turn_endpointer import evte_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_item_t                   out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t   cfg;
  logic   fe_valid;
  logic   fe_stall;
  frame_t fe_item;

  evte_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  evte_frame_energy u_energy (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .fe_valid (fe_valid),
    .fe_stall (fe_stall),
    .fe_item  (fe_item)
  );

  evte_turn_ctrl u_turn (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fe_valid  (fe_valid),
    .fe_stall  (fe_stall),
    .fe_item   (fe_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the energy VAD turn endpointer: framing, energy, turns, requests.
module tb;
  import evte_pkg::*;

  localparam int LATENCY     = 4;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_LIMIT = 5000;
  localparam int CYCLE_LIMIT = 50000;
  localparam int PRINT_LIMIT = 30;
  localparam logic [REQ_W-1:0]       REQ_LAST = '1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST = '1;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;

  // Endpointer image: registers and turn state
  cfg_t                m_cfg;
  int                  m_fill;
  longint unsigned     m_acc;
  logic [SPEECH_W-1:0] m_speech;
  logic [COUNT_W-1:0]  m_silence;
  logic [COUNT_W-1:0]  m_collected;
  logic                m_wait;
  logic [SEQ_W-1:0]    m_seq;
  logic [SEQ_W-1:0]    m_turns;

  out_item_t endpoint_q[$];
  out_item_t last_result;

  int errors           = 0;
  int items_sent       = 0;
  int results_seen     = 0;
  int frames_checked   = 0;
  int commits_checked  = 0;
  int settings_applied = 0;

  energy_vad_turn_endpointer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void clear_turn_counts();
    m_speech    = '0;
    m_silence   = '0;
    m_collected = '0;
  endfunction

  function automatic void reset_endpointer_image();
    m_cfg.energy_threshold     = RST_ENERGY_THRESHOLD;
    m_cfg.agent_mode           = RST_AGENT_MODE;
    m_cfg.min_speech_frames    = RST_MIN_SPEECH;
    m_cfg.min_collected_frames = RST_MIN_COLLECTED;
    m_cfg.silence_limit        = RST_SILENCE_LIMIT;
    m_cfg.max_collected_frames = RST_MAX_COLLECTED;
    m_fill  = 0;
    m_acc   = 0;
    m_wait  = 1'b0;
    m_seq   = '0;
    m_turns = '0;
    clear_turn_counts();
  endfunction

  // Advances the endpointer image by one item and returns the result it produces
  function automatic out_item_t step_endpointer(input in_item_t it);
    out_item_t           r;
    int                  smp;
    longint unsigned     mag;
    longint unsigned     avg;
    logic [ENERGY_W-1:0] nrg;
    r = '0;
    case (it.req_type)
      REQ_SAMPLE: begin
        smp = $signed(it.sample);
        mag = (smp < 0) ? longint'(-smp) : longint'(smp);
        m_acc += mag * mag;
        m_fill++;
        if (m_fill >= FRAME_SAMPLES) begin
          avg = (m_acc / FRAME_SAMPLES) >> ENERGY_SHIFT;
          nrg = (avg > ENERGY_MAX) ? ENERGY_MAX : avg[ENERGY_W-1:0];
          m_fill = 0;
          m_acc  = 0;
          r.frame_done   = 1'b1;
          r.frame_energy = nrg;
          r.frame_seq    = m_seq;
          if (it.call_active && !m_wait && m_cfg.agent_mode) begin
            if (nrg > m_cfg.energy_threshold) begin
              if (m_speech != '1) m_speech++;
              m_silence = '0;
            end else if (m_speech != 0) begin
              if (m_silence != '1) m_silence++;
            end
            if (m_speech >= m_cfg.min_speech_frames && m_collected != '1) m_collected++;
            if (m_collected >= m_cfg.min_collected_frames &&
                (m_silence >= m_cfg.silence_limit ||
                 m_collected >= m_cfg.max_collected_frames)) begin
              m_wait = 1'b1;
              m_turns++;
              r.commit  = 1'b1;
              r.turn_id = m_turns;
              clear_turn_counts();
            end
          end
          m_seq++;
        end
      end
      REQ_TURN_DONE: begin
        m_wait = 1'b0;
        clear_turn_counts();
      end
      REQ_CALL_START: begin
        m_seq  = '0;
        m_wait = 1'b0;
      end
      REQ_RESTART: begin
        m_fill = 0;
        m_acc  = 0;
        m_seq  = '0;
        m_wait = 1'b0;
        clear_turn_counts();
      end
      REQ_SEQ_RESET: m_seq = '0;
      default: ;
    endcase
    r.pending = m_wait;
    return r;
  endfunction

  function automatic in_item_t make_item(input logic [REQ_W-1:0] req,
                                         input logic [SAMPLE_W-1:0] smp,
                                         input logic call);
    in_item_t it;
    it.req_type    = req;
    it.sample      = smp;
    it.call_active = call;
    return it;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample(input int level);
    return SAMPLE_W'($urandom_range(0, 2 * level) - level);
  endfunction

  function automatic in_item_t rand_ctrl();
    return make_item(REQ_W'($urandom_range(REQ_TURN_DONE, REQ_LAST)),
                     SAMPLE_W'($urandom), 1'($urandom));
  endfunction

  function automatic in_item_t rand_item();
    if ($urandom_range(0, 9) < 7)
      return make_item(REQ_SAMPLE, SAMPLE_W'($urandom), 1'($urandom));
    return rand_ctrl();
  endfunction

  function automatic cfg_t make_cfg(input int thr, input int agent, input int min_sp,
                                    input int min_col, input int sil, input int max_col);
    cfg_t c;
    c.energy_threshold     = ENERGY_W'(thr);
    c.agent_mode           = 1'(agent);
    c.min_speech_frames    = SPEECH_W'(min_sp);
    c.min_collected_frames = COUNT_W'(min_col);
    c.silence_limit        = COUNT_W'(sil);
    c.max_collected_frames = COUNT_W'(max_col);
    return c;
  endfunction

  function automatic cfg_t rand_cfg();
    return make_cfg($urandom_range(0, 3000), $urandom_range(0, 7) != 0, $urandom_range(0, 4),
                    $urandom_range(0, 8), $urandom_range(0, 6), $urandom_range(0, 12));
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (errors < PRINT_LIMIT)
      $display("ERROR result %0d: %s got 0x%0h expected 0x%0h", results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (endpoint_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_data.frame_seq, 0);
      end else begin
        want = endpoint_q.pop_front();
        if (out_data.frame_done !== want.frame_done)
          report_mismatch("frame_done", out_data.frame_done, want.frame_done);
        if (out_data.frame_energy !== want.frame_energy)
          report_mismatch("frame_energy", out_data.frame_energy, want.frame_energy);
        if (out_data.frame_seq !== want.frame_seq)
          report_mismatch("frame_seq", out_data.frame_seq, want.frame_seq);
        if (out_data.commit !== want.commit)
          report_mismatch("commit", out_data.commit, want.commit);
        if (out_data.turn_id !== want.turn_id)
          report_mismatch("turn_id", out_data.turn_id, want.turn_id);
        if (out_data.pending !== want.pending)
          report_mismatch("pending", out_data.pending, want.pending);
        if (want.frame_done) frames_checked++;
        if (want.commit) commits_checked++;
      end
      results_seen++;
    end
  end

  // Result side stall: short random bursts, or one long hold on request
  initial begin : result_stall
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    last_result = step_endpointer(it);
    endpoint_q.push_back(last_result);
    items_sent++;
  endtask

  // Sends samples until a frame closes; call_active of the closing sample is call_on
  task automatic send_frame(input int level, input bit call_on, input int ctrl_permille,
                            input bit fixed);
    in_item_t it;
    do begin
      if (ctrl_permille > 0 && $urandom_range(0, 999) < ctrl_permille) send_item(rand_ctrl());
      it.req_type    = REQ_SAMPLE;
      it.sample      = fixed ? SAMPLE_W'(level) : rand_sample(level);
      it.call_active = (m_fill == FRAME_SAMPLES - 1) ? call_on : 1'($urandom);
      send_item(it);
    end while (!last_result.frame_done);
  endtask

  task automatic wait_idle();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (endpoint_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENERGY_THRESHOLD: m_cfg.energy_threshold     = val[ENERGY_W-1:0];
      CFG_AGENT_MODE:       m_cfg.agent_mode           = val[0];
      CFG_MIN_SPEECH:       m_cfg.min_speech_frames    = val[SPEECH_W-1:0];
      CFG_MIN_COLLECTED:    m_cfg.min_collected_frames = val;
      CFG_SILENCE_LIMIT:    m_cfg.silence_limit        = val;
      CFG_MAX_COLLECTED:    m_cfg.max_collected_frames = val;
      default: ;
    endcase
  endtask

  // Unused upper data bits carry junk; unmapped indexes are written too
  task automatic apply_cfg(input cfg_t c);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_ENERGY_THRESHOLD, {junk[15], c.energy_threshold});
    write_reg(CFG_AGENT_MODE, {junk[15:1], c.agent_mode});
    write_reg(CFG_MIN_SPEECH, {junk[15:8], c.min_speech_frames});
    write_reg(CFG_MIN_COLLECTED, c.min_collected_frames);
    write_reg(CFG_SILENCE_LIMIT, c.silence_limit);
    write_reg(CFG_MAX_COLLECTED, c.max_collected_frames);
    write_reg(CFG_LAST, junk);
    write_reg(CFG_MAX_COLLECTED + 3'd1, ~junk);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic test_directed_requests();
    send_item(make_item(REQ_SAMPLE, 16'h7FFF, 1'b1));
    send_item(make_item(REQ_SAMPLE, 16'h8000, 1'b0));
    send_item(make_item(REQ_SAMPLE, 16'h0000, 1'b1));
    send_item(make_item(REQ_SAMPLE, 16'hFFFF, 1'b0));
    send_item(make_item(REQ_SAMPLE, 16'h0001, 1'b1));
    send_item(make_item(REQ_SAMPLE, 16'h5555, 1'b1));
    send_item(make_item(REQ_SAMPLE, 16'hAAAA, 1'b0));
    send_item(make_item(REQ_TURN_DONE, 16'hFFFF, 1'b1));
    send_item(make_item(REQ_CALL_START, 16'h0000, 1'b0));
    send_item(make_item(REQ_SEQ_RESET, 16'h8000, 1'b1));
    send_item(make_item(REQ_SEQ_RESET + 3'd1, 16'h7FFF, 1'b0));
    send_item(make_item(REQ_SEQ_RESET + 3'd2, 16'hAAAA, 1'b1));
    send_item(make_item(REQ_LAST, 16'h5555, 1'b0));
    send_item(make_item(REQ_SAMPLE, 16'h8000, 1'b1));
    send_item(make_item(REQ_RESTART, 16'h1234, 1'b1));
    send_item(make_item(REQ_SAMPLE, 16'h7FFF, 1'b0));
    send_item(make_item(REQ_RESTART, 16'hEDCB, 1'b0));
  endtask

  // Loud frame near the saturation point; zero limits make it commit a turn
  task automatic test_frame_commit();
    wait_idle();
    apply_cfg(make_cfg(0, 1, 0, 0, 0, 0));
    send_frame(20000, 1'b1, 0, 1'b0);
    send_item(make_item(REQ_TURN_DONE, 16'h0000, 1'b1));
  endtask

  task automatic test_random_noise();
    int i;
    wait_idle();
    apply_cfg(rand_cfg());
    for (i = 0; i < 60; i++) send_item(rand_item());
  endtask

  task automatic test_backpressure();
    int i;
    hold_req = 1'b1;
    for (i = 0; i < 40; i++) send_item(rand_item());
  endtask

  task automatic test_final_no_idle();
    int i;
    wait_idle();
    idle_on = 1'b0;
    apply_cfg(rand_cfg());
    for (i = 0; i < 20; i++) send_item(rand_item());
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    reset_endpointer_image();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_requests();
    test_frame_commit();
    test_random_noise();
    test_backpressure();
    test_final_no_idle();
    wait_idle();
    if (endpoint_q.size() != 0)
      report_mismatch("results never delivered", endpoint_q.size(), 0);
    $display("Run covered %0d items, %0d closed frames and %0d turn commits,",
             items_sent, frames_checked, commits_checked);
    $display("over %0d register settings including zero limits, random stalls and a long hold",
             settings_applied);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
